FILE: hdl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and decode helpers for the scalar field serializer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int unsigned ValW     = 64;
    localparam int unsigned CntW     = 32;
    localparam int unsigned LenW     = 4;
    localparam int unsigned RoomW    = 4;
    localparam int unsigned OpW      = 4;
    localparam int unsigned FmtW     = 2;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned MaxBytes = 10;
    localparam int unsigned VarBits  = 7;
    localparam int unsigned VarGroups = MaxBytes - 1;

    typedef logic [OpW-1:0]  t_op_code;
    typedef logic [FmtW-1:0] t_fmt_code;

    // type codes
    localparam t_op_code OP_UBYTE  = 4'd0;
    localparam t_op_code OP_SBYTE  = 4'd1;
    localparam t_op_code OP_USHORT = 4'd2;
    localparam t_op_code OP_SSHORT = 4'd3;
    localparam t_op_code OP_UINT   = 4'd4;
    localparam t_op_code OP_SINT   = 4'd5;
    localparam t_op_code OP_ULONG  = 4'd6;
    localparam t_op_code OP_SLONG  = 4'd7;
    localparam t_op_code OP_FLOAT  = 4'd8;
    localparam t_op_code OP_DOUBLE = 4'd9;

    // format codes
    localparam t_fmt_code FMT_LE  = 2'd0;
    localparam t_fmt_code FMT_BE  = 2'd1;
    localparam t_fmt_code FMT_VAR = 2'd2;

    typedef enum logic [1:0] {MODE_LE, MODE_BE, MODE_VAR} t_mode;
    typedef enum logic [1:0] {WID_8, WID_16, WID_32, WID_64} t_wid;
    typedef enum logic [1:0] {ST_IDLE, ST_SIZE, ST_EMIT} t_state;

    typedef struct packed {
        t_wid wid;
        logic sgn;
        logic flt;
    } t_kind;

    // sequencer -> shift unit
    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_ctl;

    // sequencer -> output channel
    typedef struct packed {
        logic            valid;
        logic            last;
        logic            no_room;
        logic [LenW-1:0] len;
        logic [CntW-1:0] total;
    } t_res_stat;

    function automatic t_kind decode_op(input t_op_code op);
        t_kind k;
        k = '{wid: WID_8, sgn: 1'b0, flt: 1'b0};
        unique case (op)
            OP_USHORT: k.wid = WID_16;
            OP_SSHORT: begin k.wid = WID_16; k.sgn = 1'b1; end
            OP_UINT:   k.wid = WID_32;
            OP_SINT:   begin k.wid = WID_32; k.sgn = 1'b1; end
            OP_ULONG:  k.wid = WID_64;
            OP_SLONG:  begin k.wid = WID_64; k.sgn = 1'b1; end
            OP_FLOAT:  begin k.wid = WID_32; k.flt = 1'b1; end
            OP_DOUBLE: begin k.wid = WID_64; k.flt = 1'b1; end
            default:   k.wid = WID_8;  // byte types and unused codes
        endcase
        return k;
    endfunction

    function automatic t_mode pick_mode(input t_kind k, input t_fmt_code fmt);
        t_mode m;
        if (k.wid == WID_8) begin
            m = MODE_LE;
        end else if (fmt == FMT_BE) begin
            m = MODE_BE;
        end else if (fmt == FMT_VAR && !k.flt) begin
            m = MODE_VAR;
        end else begin
            m = MODE_LE;
        end
        return m;
    endfunction

endpackage

FILE: hdl/sfs_in_if.sv
// ----------------------------------------------------------------------------
// sfs_in_if
// Input item channel: valid/ready plus one scalar to serialize.
// ----------------------------------------------------------------------------
interface sfs_in_if;
    logic                           valid;
    logic                           ready;
    logic [sfs_pkg::OpW-1:0]        op;
    logic [sfs_pkg::FmtW-1:0]       format;
    logic [sfs_pkg::ValW-1:0]       value;
    logic [sfs_pkg::RoomW-1:0]      room;

    modport source (output valid, op, format, value, room, input ready);
    modport sink   (input valid, op, format, value, room, output ready);
endinterface

FILE: hdl/sfs_out_if.sv
// ----------------------------------------------------------------------------
// sfs_out_if
// Result item channel: one serialized byte per item.
// ----------------------------------------------------------------------------
interface sfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfs_pkg::ByteW-1:0]     data_byte;
    logic                          last;
    logic                          no_room;
    logic [sfs_pkg::LenW-1:0]      needed_length;
    logic [sfs_pkg::CntW-1:0]      running_count;

    modport source (output valid, data_byte, last, no_room, needed_length,
                    running_count, input ready);
    modport sink   (input valid, data_byte, last, no_room, needed_length,
                    running_count, output ready);
endinterface

FILE: hdl/sfs_dp.sv
// ----------------------------------------------------------------------------
// sfs_dp
// Shared shift unit: holds the prepared value and peels one byte per step.
// ----------------------------------------------------------------------------
module sfs_dp (
    input  logic                          i_clk,
    input  sfs_pkg::t_dp_ctl              i_ctl,
    input  sfs_pkg::t_op_code             i_op,
    input  sfs_pkg::t_fmt_code            i_format,
    input  logic [sfs_pkg::ValW-1:0]      i_value,
    output logic [sfs_pkg::ByteW-1:0]     o_byte,
    output logic [sfs_pkg::LenW-1:0]      o_len
);

    sfs_pkg::t_kind             kind;
    sfs_pkg::t_mode             mode;
    logic [sfs_pkg::ValW-1:0]   mask;
    logic                       sign;
    logic [sfs_pkg::ValW-1:0]   v_m;
    logic [sfs_pkg::ValW-1:0]   v_zz;
    logic [sfs_pkg::ValW-1:0]   n_val;
    logic [sfs_pkg::VarGroups-1:0] grp;

    logic [sfs_pkg::ValW-1:0]   r_val;
    sfs_pkg::t_mode             r_mode;
    sfs_pkg::t_wid              r_wid;

    // load-time preparation: mask, zigzag, big endian left alignment
    always_comb begin
        kind = sfs_pkg::decode_op(i_op);
        mode = sfs_pkg::pick_mode(kind, i_format);
        unique case (kind.wid)
            sfs_pkg::WID_8:  begin mask = 64'h0000_0000_0000_00FF; sign = i_value[7];  end
            sfs_pkg::WID_16: begin mask = 64'h0000_0000_0000_FFFF; sign = i_value[15]; end
            sfs_pkg::WID_32: begin mask = 64'h0000_0000_FFFF_FFFF; sign = i_value[31]; end
            sfs_pkg::WID_64: begin mask = 64'hFFFF_FFFF_FFFF_FFFF; sign = i_value[63]; end
            default:         begin mask = '1; sign = 1'b0; end
        endcase
        v_m  = i_value & mask;
        v_zz = ((v_m << 1) ^ (sign ? mask : '0)) & mask;
        n_val = v_m;
        if (mode == sfs_pkg::MODE_VAR && kind.sgn) begin
            n_val = v_zz;
        end else if (mode == sfs_pkg::MODE_BE) begin
            unique case (kind.wid)
                sfs_pkg::WID_16: n_val = v_m << 48;
                sfs_pkg::WID_32: n_val = v_m << 32;
                default:         n_val = v_m;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val  <= n_val;
            r_mode <= mode;
            r_wid  <= kind.wid;
        end else if (i_ctl.shift) begin
            unique case (r_mode)
                sfs_pkg::MODE_BE:  r_val <= r_val << sfs_pkg::ByteW;
                sfs_pkg::MODE_VAR: r_val <= r_val >> sfs_pkg::VarBits;
                default:           r_val <= r_val >> sfs_pkg::ByteW;
            endcase
        end
    end

    // current byte
    always_comb begin
        unique case (r_mode)
            sfs_pkg::MODE_BE:  o_byte = r_val[sfs_pkg::ValW-1 -: sfs_pkg::ByteW];
            sfs_pkg::MODE_VAR: o_byte = {|r_val[sfs_pkg::ValW-1:sfs_pkg::VarBits],
                                         r_val[sfs_pkg::VarBits-1:0]};
            default:           o_byte = r_val[sfs_pkg::ByteW-1:0];
        endcase
    end

    // length; valid the cycle after load. Nonzero 7-bit groups are monotone,
    // so the varint length is one plus their count.
    always_comb begin
        for (int k = 0; k < sfs_pkg::VarGroups; k++) begin
            grp[k] = |(r_val >> (sfs_pkg::VarBits * (k + 1)));
        end
        if (r_mode == sfs_pkg::MODE_VAR) begin
            o_len = sfs_pkg::LenW'($countones(grp)) + sfs_pkg::LenW'(1);
        end else begin
            unique case (r_wid)
                sfs_pkg::WID_16: o_len = sfs_pkg::LenW'(2);
                sfs_pkg::WID_32: o_len = sfs_pkg::LenW'(4);
                sfs_pkg::WID_64: o_len = sfs_pkg::LenW'(8);
                default:         o_len = sfs_pkg::LenW'(1);
            endcase
        end
    end

endmodule

FILE: hdl/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer: load, size, emit; byte counter, room check and running total.
// ----------------------------------------------------------------------------
module sfs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_out_ready,
    input  logic [sfs_pkg::RoomW-1:0]     i_room,
    input  logic [sfs_pkg::LenW-1:0]      i_len,
    output logic                          o_in_ready,
    output sfs_pkg::t_dp_ctl              o_dp,
    output sfs_pkg::t_res_stat            o_stat
);

    sfs_pkg::t_state               r_state;
    sfs_pkg::t_state               n_state;
    logic [sfs_pkg::LenW-1:0]      r_cnt;
    logic [sfs_pkg::LenW-1:0]      r_len;
    logic [sfs_pkg::RoomW-1:0]     r_room;
    logic                          r_nroom;
    logic [sfs_pkg::CntW-1:0]      r_total;
    logic                          last;

    assign last = r_nroom || ((r_cnt + sfs_pkg::LenW'(1)) == r_len);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfs_pkg::ST_IDLE: if (i_in_valid) n_state = sfs_pkg::ST_SIZE;
            sfs_pkg::ST_SIZE: n_state = sfs_pkg::ST_EMIT;
            sfs_pkg::ST_EMIT: if (i_out_ready && last) n_state = sfs_pkg::ST_IDLE;
            default:          n_state = sfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == sfs_pkg::ST_IDLE);
        o_dp.load      = o_in_ready && i_in_valid;
        o_dp.shift     = (r_state == sfs_pkg::ST_EMIT) && i_out_ready && !last;
        o_stat.valid   = (r_state == sfs_pkg::ST_EMIT);
        o_stat.last    = last;
        o_stat.no_room = r_nroom;
        o_stat.len     = r_len;
        o_stat.total   = r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfs_pkg::ST_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == sfs_pkg::ST_SIZE) begin
                r_total <= r_total + sfs_pkg::CntW'(i_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_dp.load) begin
            r_room <= i_room;
        end
        if (r_state == sfs_pkg::ST_SIZE) begin
            r_len   <= i_len;
            r_nroom <= (r_room < i_len);
            r_cnt   <= '0;
        end else if (o_dp.shift) begin
            r_cnt <= r_cnt + sfs_pkg::LenW'(1);
        end
    end

endmodule

FILE: hdl/scalar_field_serializer_top.sv
// ----------------------------------------------------------------------------
// scalar_field_serializer_top
// Serializes one scalar per item into bytes: little/big endian or LEB128.
// ----------------------------------------------------------------------------
// One input item is taken, then the block is busy until its last result item
// has been taken. Each item is loaded and prepared (mask, zigzag for signed
// varints, big endian alignment), then sized and checked for room, then
// gives one result item per output byte, N = 1..10 bytes (1 when there is
// no room). The byte loop runs on a single shift register that moves 8 bits
// (fixed formats) or 7 bits (varint) per result, so the output byte rate
// sets the throughput. The running count on every result includes the
// current item, and grows even when the item reports no room. Byte types
// ignore the format; float and double treat varint as little endian;
// unused type codes act as unsigned byte and format 3 as little endian.
// ----------------------------------------------------------------------------
module scalar_field_serializer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfs_in_if.sink     i_item,
    sfs_out_if.source  o_res
);

    sfs_pkg::t_dp_ctl              dp_ctl;
    sfs_pkg::t_res_stat            stat;
    logic [sfs_pkg::ByteW-1:0]     dp_byte;
    logic [sfs_pkg::LenW-1:0]      dp_len;

    // sequencer
    sfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_res.ready),
        .i_room      (i_item.room),
        .i_len       (dp_len),
        .o_in_ready  (i_item.ready),
        .o_dp        (dp_ctl),
        .o_stat      (stat)
    );

    // shared shift unit
    sfs_dp u_dp (
        .i_clk    (i_clk),
        .i_ctl    (dp_ctl),
        .i_op     (i_item.op),
        .i_format (i_item.format),
        .i_value  (i_item.value),
        .o_byte   (dp_byte),
        .o_len    (dp_len)
    );

    // result fields come straight from registers; no-room item carries zero
    assign o_res.valid         = stat.valid;
    assign o_res.data_byte     = stat.no_room ? '0 : dp_byte;
    assign o_res.last          = stat.last;
    assign o_res.no_room       = stat.no_room;
    assign o_res.needed_length = stat.len;
    assign o_res.running_count = stat.total;

endmodule

FILE: hdl/sfs_chk.sv
// ----------------------------------------------------------------------------
// sfs_chk
// Port-level checks for the serializer, bound to the top level.
// ----------------------------------------------------------------------------
module sfs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sfs_pkg::ByteW-1:0]     i_data_byte,
    input logic                          i_last,
    input logic                          i_no_room,
    input logic [sfs_pkg::LenW-1:0]      i_len,
    input logic [sfs_pkg::CntW-1:0]      i_count
);

    // a no-room item is a single zero byte
    a_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_no_room |-> i_last && i_data_byte == '0)
        else $error("no-room result not a single zero item");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_len != '0 && i_len <= sfs_pkg::LenW'(sfs_pkg::MaxBytes))
        else $error("needed length out of range");

    // busy while results are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready && !i_out_valid)
        else $error("accepted new item while busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while results pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_count))
        else $error("stalled result changed");

endmodule

bind scalar_field_serializer_top sfs_chk u_sfs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_data_byte (o_res.data_byte),
    .i_last      (o_res.last),
    .i_no_room   (o_res.no_room),
    .i_len       (o_res.needed_length),
    .i_count     (o_res.running_count)
);
